/* sv/swrc_pkg.sv */
// Shared types, codes and result formatting for the stop-and-wait receive classifier.
`timescale 1ns / 1ps
`default_nettype none

package swrc_pkg;

    // Request kinds carried in the low bit of the input tuser
    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    // Packet kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_CONN = 2'd2;

    // Result status codes
    localparam logic [2:0] STS_DATA_OK = 3'd0;
    localparam logic [2:0] STS_CONN_OK = 3'd1;
    localparam logic [2:0] STS_ACK     = 3'd2;
    localparam logic [2:0] STS_DUP     = 3'd3;
    localparam logic [2:0] STS_DROP    = 3'd4;
    localparam logic [2:0] STS_BAD     = 3'd5;
    localparam logic [2:0] STS_FULL    = 3'd6;
    localparam logic [2:0] STS_BOX_SET = 3'd7;

    // Configuration register indexes
    localparam logic [7:0] CFG_BOX_COUNT  = 8'd0;
    localparam logic [7:0] CFG_LISTEN_BOX = 8'd1;

    // Operation decided by the front end
    typedef enum logic [2:0] {
        OP_BAD,
        OP_SET,
        OP_ACK,
        OP_DATA,
        OP_CONN,
        OP_DROP
    } t_op;

    // Classified request handed from front to back
    typedef struct packed {
        t_op         op;
        logic [7:0]  src_machine;
        logic [7:0]  dst_machine;
        logic [7:0]  src_box;
        logic [7:0]  dst_box;
        logic [15:0] msg_id;
        logic [31:0] conn_time;
        logic [15:0] new_expected;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [2:0]  status;
        logic        send_ack;
        logic [7:0]  ack_from_machine;
        logic [7:0]  ack_to_machine;
        logic [7:0]  ack_from_box;
        logic [7:0]  ack_to_box;
        logic [15:0] ack_id;
        logic [3:0]  target_box;
    } t_result;

    // Build a result; acknowledgement fields swap source and destination
    function automatic t_result make_result(t_cmd c, logic [2:0] st, logic ack);
        t_result r;
        r          = '0;
        r.status   = st;
        r.send_ack = ack;
        if (ack) begin
            r.ack_from_machine = c.dst_machine;
            r.ack_to_machine   = c.src_machine;
            r.ack_from_box     = c.dst_box;
            r.ack_to_box       = c.src_box;
            r.ack_id           = c.msg_id;
        end
        if (st != STS_BAD) begin
            r.target_box = c.dst_box[3:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/stop_wait_receive_classifier.sv */
// Top level: configuration registers, front end, request queue and back end.
//
// Usage:
//   Requests enter on the s_axis channel: tuser holds req_type and msg_kind,
//   tdata the addresses, ids and timestamp. One result per request leaves on
//   the m_axis channel: tuser holds status and send_ack, tdata the
//   acknowledgement header and the target box.
//   Configuration writes use i_cfg_valid/o_cfg_ready with a register index
//   (0 box count, 1 listen box); o_cfg_ready is always high.
//   m_axis_tvalid rises once a request has passed the queue and the result
//   register for bad-box, set, ack and drop requests; DATA also waits for its
//   expected-id read and a connection request for the table scan, entries read
//   one per cycle. The back end takes nothing new while DATA or a connection is
//   in progress; simple requests flow at one per cycle while m_axis_tready is high.
//   A two-entry queue lets the front accept while a result waits.
//   Reset sets box count 16, listen box 0, clears expected ids, marks every
//   box as having no acknowledgement and empties the connection table; no
//   clearing pass is needed.
//   A stalled receiver holds the result register; the queue then fills and
//   s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module stop_wait_receive_classifier
    import swrc_pkg::*;
#(
    parameter int BOXES      = 16,
    parameter int CONN_SLOTS = 16,
    parameter int ID_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // src_machine, dst_machine, src_box, dst_box,
                                            // msg_id, conn_time, new_expected
    input  wire logic [2:0]  s_axis_tuser,  // req_type, msg_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // ack_from_machine, ack_to_machine, ack_from_box,
                                            // ack_to_box, ack_id, target_box, zero pad
    output logic [3:0]       m_axis_tuser,  // status, send_ack
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [4:0] r_box_count;
    logic [3:0] r_listen_box;
    logic       push;
    logic       full;
    logic       pop;
    logic       q_valid;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    t_result    result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count  <= 5'd16;
            r_listen_box <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOX_COUNT:  r_box_count  <= i_cfg_data[4:0];
                CFG_LISTEN_BOX: r_listen_box <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    swrc_front #(
        .BOXES (BOXES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_box_count   (r_box_count),
        .i_listen_box  (r_listen_box),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    swrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    swrc_back #(
        .BOXES      (BOXES),
        .CONN_SLOTS (CONN_SLOTS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_cmd_valid    (q_valid),
        .o_cmd_pop      (pop),
        .o_result       (result),
        .o_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready)
    );

    // Pack the result transfer
    assign m_axis_tuser = {result.send_ack, result.status};
    assign m_axis_tdata = {4'b0000, result.target_box, result.ack_id,
                           result.ack_to_box, result.ack_from_box,
                           result.ack_to_machine, result.ack_from_machine};

endmodule

`default_nettype wire

/* sv/swrc_front.sv */
// Front end: accepts request transfers and classifies them into operations.
`timescale 1ns / 1ps
`default_nettype none

module swrc_front
    import swrc_pkg::*;
#(
    parameter int BOXES = 16
) (
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // src_machine, dst_machine, src_box, dst_box,
                                            // msg_id, conn_time, new_expected
    input  wire logic [2:0]  s_axis_tuser,  // req_type, msg_kind
    input  wire logic [4:0]  i_box_count,
    input  wire logic [3:0]  i_listen_box,
    input  wire logic        i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam logic [8:0] BOX_LIM = 9'(BOXES);

    logic       req_type;
    logic [1:0] msg_kind;
    logic       bad_box;
    t_cmd       cmd;

    // Unpack the transfer
    always_comb begin
        req_type         = s_axis_tuser[0];
        msg_kind         = s_axis_tuser[2:1];
        cmd.src_machine  = s_axis_tdata[7:0];
        cmd.dst_machine  = s_axis_tdata[15:8];
        cmd.src_box      = s_axis_tdata[23:16];
        cmd.dst_box      = s_axis_tdata[31:24];
        cmd.msg_id       = s_axis_tdata[47:32];
        cmd.conn_time    = s_axis_tdata[79:48];
        cmd.new_expected = s_axis_tdata[95:80];

        // Flag boxes beyond the configured count or the built-in count
        bad_box = ({1'b0, cmd.dst_box} >= {4'b0000, i_box_count}) ||
                  ({1'b0, cmd.dst_box} >= BOX_LIM);

        if (bad_box) begin
            cmd.op = OP_BAD;
        end else if (req_type == REQ_SET) begin
            cmd.op = OP_SET;
        end else if (msg_kind == KIND_ACK) begin
            cmd.op = OP_ACK;
        end else if (msg_kind == KIND_DATA) begin
            cmd.op = OP_DATA;
        end else if (msg_kind == KIND_CONN && cmd.dst_box == {4'b0000, i_listen_box}) begin
            cmd.op = OP_CONN;
        end else begin
            cmd.op = OP_DROP;
        end
    end

    // Hand classified requests to the queue while it has room
    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;
    assign o_cmd         = cmd;

endmodule

`default_nettype wire

/* sv/swrc_fifo.sv */
// Two-entry queue of classified requests between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module swrc_fifo
    import swrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/swrc_back.sv */
// Back end: mailbox id updates, connection table search and the result register.
`timescale 1ns / 1ps
`default_nettype none

module swrc_back
    import swrc_pkg::*;
#(
    parameter int BOXES      = 16,
    parameter int CONN_SLOTS = 16,
    parameter int ID_BITS    = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    output t_result   o_result,
    output logic      o_result_valid,
    input  wire logic i_result_ready
);

    localparam int BOX_W = $clog2(BOXES);
    localparam int IDX_W = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int CNT_W = $clog2(CONN_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXP,
        S_SCAN
    } t_state;

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic    r_rd_vld, n_rd_vld;

    // Mailbox stores and connection table
    logic [ID_BITS-1:0] r_exp_mem [BOXES];
    logic [ID_BITS:0]   r_last_ack [BOXES];
    logic [63:0]        r_conn_mem [CONN_SLOTS];
    logic [BOXES-1:0]   r_exp_vld;
    logic [BOXES-1:0]   r_ack_vld;
    logic [ID_BITS-1:0] r_exp_q;
    logic [63:0]        r_conn_q;

    logic               out_free;
    logic               take;
    logic [BOX_W-1:0]   head_box;
    logic [BOX_W-1:0]   cur_box;
    logic [BOX_W-1:0]   exp_addr;
    logic               exp_we;
    logic               exp_re;
    logic [ID_BITS-1:0] exp_wdata;
    logic [ID_BITS-1:0] exp_cur;
    logic [ID_BITS-1:0] id_cur;
    logic               ack_we;
    logic               conn_we;
    logic               conn_re;
    logic [IDX_W-1:0]   conn_addr;
    logic               hit;

    assign out_free  = !r_out_valid || i_result_ready;
    assign take      = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_pop = take;
    assign head_box  = i_cmd.dst_box[BOX_W-1:0];
    assign cur_box   = r_cmd.dst_box[BOX_W-1:0];
    assign exp_addr  = (r_state == S_IDLE) ? head_box : cur_box;
    assign exp_cur   = r_exp_vld[cur_box] ? r_exp_q : '0;
    assign id_cur    = ID_BITS'(r_cmd.msg_id);
    assign conn_addr = conn_we ? r_fill[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign hit       = r_rd_vld &&
                       (r_conn_q[63:32] == {r_cmd.src_machine, r_cmd.dst_machine,
                                            r_cmd.src_box, r_cmd.dst_box}) &&
                       (r_conn_q[31:0] >= r_cmd.conn_time);

    // Sequence one request at a time
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_result_ready;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_rd_vld    = r_rd_vld;
        exp_we      = 1'b0;
        exp_re      = 1'b0;
        exp_wdata   = ID_BITS'(i_cmd.new_expected);
        ack_we      = 1'b0;
        conn_we     = 1'b0;
        conn_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        OP_BAD: begin
                            n_out       = make_result(i_cmd, STS_BAD, 1'b0);
                            n_out_valid = 1'b1;
                        end
                        OP_SET: begin
                            exp_we      = 1'b1;
                            n_out       = make_result(i_cmd, STS_BOX_SET, 1'b0);
                            n_out_valid = 1'b1;
                        end
                        OP_ACK: begin
                            ack_we      = 1'b1;
                            n_out       = make_result(i_cmd, STS_ACK, 1'b0);
                            n_out_valid = 1'b1;
                        end
                        OP_DATA: begin
                            exp_re  = 1'b1;
                            n_state = S_EXP;
                        end
                        OP_CONN: begin
                            n_idx    = '0;
                            n_rd_vld = 1'b0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_out       = make_result(i_cmd, STS_DROP, 1'b1);
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_EXP: begin
                // Deliver the expected id and advance it, else drop
                if (id_cur == exp_cur) begin
                    exp_we    = 1'b1;
                    exp_wdata = exp_cur + {{(ID_BITS-1){1'b0}}, 1'b1};
                    n_out     = make_result(r_cmd, STS_DATA_OK, 1'b1);
                end else begin
                    n_out     = make_result(r_cmd, STS_DROP, 1'b1);
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                // One table entry read per cycle, compared in the cycle after its read
                if (hit) begin
                    n_out       = make_result(r_cmd, STS_DUP, 1'b1);
                    n_out_valid = 1'b1;
                    n_rd_vld    = 1'b0;
                    n_state     = S_IDLE;
                end else if (r_idx < r_fill) begin
                    conn_re  = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end else if (r_rd_vld) begin
                    n_rd_vld = 1'b0;
                end else begin
                    if (r_fill == CNT_W'(CONN_SLOTS)) begin
                        n_out = make_result(r_cmd, STS_FULL, 1'b1);
                    end else begin
                        conn_we = 1'b1;
                        n_fill  = r_fill + CNT_W'(1);
                        n_out   = make_result(r_cmd, STS_CONN_OK, 1'b1);
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_exp_vld   <= '0;
            r_ack_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_rd_vld    <= n_rd_vld;
            if (exp_we) begin
                r_exp_vld[exp_addr] <= 1'b1;
            end
            if (ack_we) begin
                r_ack_vld[head_box] <= 1'b1;
            end
        end
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    // Expected-id store
    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            r_exp_mem[exp_addr] <= exp_wdata;
        end
        if (exp_re) begin
            r_exp_q <= r_exp_mem[exp_addr];
        end
    end

    // Last acknowledgement store
    always_ff @(posedge i_clk) begin
        if (ack_we) begin
            r_last_ack[head_box] <= {1'b0, ID_BITS'(i_cmd.msg_id)};
        end
    end

    // Connection table
    always_ff @(posedge i_clk) begin
        if (conn_we) begin
            r_conn_mem[conn_addr] <= {r_cmd.src_machine, r_cmd.dst_machine,
                                      r_cmd.src_box, r_cmd.dst_box, r_cmd.conn_time};
        end
        if (conn_re) begin
            r_conn_q <= r_conn_mem[conn_addr];
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CONN_SLOTS))
        else $error("connection table fill beyond slot count");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_fill))
        else $error("table scan ran past filled slots");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |->
            (r_out_valid && r_out.status == STS_CONN_OK &&
             r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("table grew without a delivered connection");

    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result register occupied while a request is in progress");

    a_ack_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == OP_ACK) |=>
            (r_ack_vld[$past(head_box)] &&
             r_last_ack[$past(head_box)] == {1'b0, ID_BITS'($past(i_cmd.msg_id))}))
        else $error("acknowledgement id not recorded");

endmodule

`default_nettype wire
